>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define GCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked property that also holds across reset
`define GCB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg
// Types and constants shared by the single-bin Goertzel blocks
// ----------------------------------------------------------------------------
package gcb_pkg;

    // fixed-point format of coefficients and state
    localparam int FRAC_BITS = 14;
    localparam int COEF_W    = 16;
    localparam int LEN_W     = 13;
    localparam int OUT_W     = 32;

    // configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_COS_W    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_W        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_W        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN      = 3'd5;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register contents
    typedef struct packed {
        logic        [LEN_W-1:0]  block_length;
        logic signed [COEF_W-1:0] two_cos_w;
        logic signed [COEF_W-1:0] cos_w;
        logic signed [COEF_W-1:0] sin_w;
        logic signed [COEF_W-1:0] rot_cos;
        logic signed [COEF_W-1:0] rot_sin;
    } cfg_t;

    // queue handshake between front and queue
    typedef struct packed {
        logic push;
    } q_ctrl_t;

endpackage

>>> rtl/goertzel_complex_bin_top.sv
// ----------------------------------------------------------------------------
// goertzel_complex_bin_top
// Single-bin Goertzel DFT over complex samples with end-of-block rotation
// ----------------------------------------------------------------------------
//  channel   direction  handshake           word
//  s_        in         s_tvalid/s_tready   sample_re, sample_im
//  m_        out        m_tvalid/m_tready   bin_re, bin_im
//  cfg_      in         cfg_valid/cfg_ready register index and value
//
//  In the arithmetic back end a sample is popped from the queue, and each
//  component then takes two half products on the shared multiplier,
//  accumulate, round and saturate. The last sample of a block goes on to
//  form A, B and the two rotated outputs.
//  A four-word queue lets intake run ahead of the arithmetic; s_tready drops
//  only when it is full. A finished bin waits in the output register while
//  the next block's samples are taken and filtered.
//  Reset is synchronous, active low; clears config, control, filter state.
// ----------------------------------------------------------------------------
module goertzel_complex_bin_top #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_LENGTH   = 4096,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input samples
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_re, sample_im (zero padded to bytes)
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // result bins
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bin_re, bin_im
    output logic [2*gcb_pkg::OUT_W-1:0]         m_tdata,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gcb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int QW = 2 * SAMPLE_WIDTH + 1;

    gcb_pkg::cfg_t    cfg_reg;
    gcb_pkg::q_ctrl_t q_ctrl;
    logic [QW-1:0]    q_in;
    logic [QW-1:0]    q_out;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_length <= gcb_pkg::LEN_W'(256);
            cfg_reg.two_cos_w    <= '0;
            cfg_reg.cos_w        <= 16'sd16384;
            cfg_reg.sin_w        <= '0;
            cfg_reg.rot_cos      <= 16'sd16384;
            cfg_reg.rot_sin      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                gcb_pkg::REG_BLOCK_LENGTH:
                    cfg_reg.block_length <= cfg_data[gcb_pkg::LEN_W-1:0];
                gcb_pkg::REG_TWO_COS_W: cfg_reg.two_cos_w <= cfg_data;
                gcb_pkg::REG_COS_W:     cfg_reg.cos_w     <= cfg_data;
                gcb_pkg::REG_SIN_W:     cfg_reg.sin_w     <= cfg_data;
                gcb_pkg::REG_ROT_COS:   cfg_reg.rot_cos   <= cfg_data;
                gcb_pkg::REG_ROT_SIN:   cfg_reg.rot_sin   <= cfg_data;
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // intake and block framing
    gcb_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .sample_bits  (s_tdata[2*SAMPLE_WIDTH-1:0]),
        .block_length (cfg_reg.block_length),
        .q_ctrl       (q_ctrl),
        .q_full       (q_full),
        .q_data       (q_in)
    );

    // queue between intake and arithmetic
    gcb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_ctrl.push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // recurrence, bin forming and output register
    gcb_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/gcb_queue.sv
// ----------------------------------------------------------------------------
// gcb_queue
// Small register queue that decouples sample intake from the arithmetic
// ----------------------------------------------------------------------------
module gcb_queue #(
    parameter int WIDTH = 33
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int DEPTH = gcb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/gcb_front.sv
// ----------------------------------------------------------------------------
// gcb_front
// Sample intake: counts samples in the block and tags the block's last one
// ----------------------------------------------------------------------------
module gcb_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_LENGTH   = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2*SAMPLE_WIDTH-1:0]       sample_bits,
    input  logic [gcb_pkg::LEN_W-1:0]       block_length,
    output gcb_pkg::q_ctrl_t                q_ctrl,
    input  logic                            q_full,
    output logic [2*SAMPLE_WIDTH:0]         q_data
);

    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int LW    = (CNT_W > gcb_pkg::LEN_W) ? CNT_W : gcb_pkg::LEN_W;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [LW-1:0]    len_raw;
    logic [LW-1:0]    len_eff;
    logic [LW-1:0]    cnt_inc;
    logic             is_last;
    logic             accept;

    assign s_tready    = !q_full;
    assign accept      = s_tvalid && s_tready;
    assign q_ctrl.push = accept;

    // effective block length: zero reads as one, long lengths clamp
    assign len_raw = LW'(block_length);
    always_comb begin
        priority if (len_raw == '0) begin
            len_eff = LW'(1);
        end else if (len_raw > LW'(MAX_LENGTH)) begin
            len_eff = LW'(MAX_LENGTH);
        end else begin
            len_eff = len_raw;
        end
    end

    // end-of-block tag
    assign cnt_inc  = LW'(cnt_reg) + LW'(1);
    assign is_last  = (cnt_inc >= len_eff);
    assign cnt_next = is_last ? '0 : cnt_inc[CNT_W-1:0];
    assign q_data   = {is_last, sample_bits};

    // sample counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/gcb_back.sv
// ----------------------------------------------------------------------------
// gcb_back
// Recurrence and end-of-block arithmetic on one shared half-width multiplier
// ----------------------------------------------------------------------------
module gcb_back #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gcb_pkg::cfg_t                 cfg,
    input  logic                          q_empty,
    input  logic [2*SAMPLE_WIDTH:0]       q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*gcb_pkg::OUT_W-1:0]   m_tdata
);

    localparam int FB    = gcb_pkg::FRAC_BITS;
    localparam int OW    = gcb_pkg::OUT_W;
    localparam int KW    = gcb_pkg::COEF_W + 1;
    localparam int H     = ACC_WIDTH / 2;
    localparam int HI_W  = ACC_WIDTH - H;
    localparam int MW    = HI_W + 1;
    localparam int PW    = MW + KW;
    localparam int WIDE  = ACC_WIDTH + 32;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // operations
    localparam logic [2:0] OP_RRE = 3'd0;
    localparam logic [2:0] OP_RIM = 3'd1;
    localparam logic [2:0] OP_A   = 3'd2;
    localparam logic [2:0] OP_B   = 3'd3;
    localparam logic [2:0] OP_ORE = 3'd4;
    localparam logic [2:0] OP_OIM = 3'd5;

    logic [2:0]                   state_reg;
    logic [2:0]                   op_reg;
    logic [1:0]                   phase_reg;
    logic signed [WIDE-1:0]       acc_reg;
    logic signed [PW-1:0]         prod_reg;
    logic                         half_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_re_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_im_reg;
    logic                         last_reg;
    logic signed [ACC_WIDTH-1:0]  prev_re_reg;
    logic signed [ACC_WIDTH-1:0]  prev_im_reg;
    logic signed [ACC_WIDTH-1:0]  prev2_re_reg;
    logic signed [ACC_WIDTH-1:0]  prev2_im_reg;
    logic signed [ACC_WIDTH-1:0]  a_reg;
    logic signed [ACC_WIDTH-1:0]  b_reg;
    logic signed [OW-1:0]         ore_reg;
    logic                         out_valid_reg;
    logic signed [OW-1:0]         out_re_reg;
    logic signed [OW-1:0]         out_im_reg;

    logic signed [KW-1:0]         tc_e, cw_n, sw_e, sw_n, rc_e, rs_e, rs_n;
    logic signed [ACC_WIDTH-1:0]  opnd;
    logic signed [KW-1:0]         coef;
    logic signed [WIDE-1:0]       base;
    logic signed [MW-1:0]         mop;
    logic signed [PW-1:0]         prod_next;
    logic signed [WIDE-1:0]       addend;
    logic signed [WIDE-1:0]       rnd_sum;
    logic signed [WIDE-1:0]       rnd_next;
    logic [1:0]                   last_phase;
    logic                         is_out_op;
    logic                         fits_acc;
    logic                         fits_out;
    logic signed [ACC_WIDTH-1:0]  sat_acc;
    logic signed [OW-1:0]         sat_out;

    // coefficient forms, negated where the sum subtracts
    assign tc_e = KW'(cfg.two_cos_w);
    assign cw_n = -KW'(cfg.cos_w);
    assign sw_e = KW'(cfg.sin_w);
    assign sw_n = -KW'(cfg.sin_w);
    assign rc_e = KW'(cfg.rot_cos);
    assign rs_e = KW'(cfg.rot_sin);
    assign rs_n = -KW'(cfg.rot_sin);

    assign is_out_op  = (op_reg == OP_ORE) || (op_reg == OP_OIM);
    assign last_phase = ((op_reg == OP_RRE) || (op_reg == OP_RIM)) ? 2'd1 : 2'd3;

    // operand, coefficient and start value of the current operation
    always_comb begin
        unique case (op_reg)
            OP_RRE: begin
                opnd = prev_re_reg;
                coef = tc_e;
                base = (WIDE'(x_re_reg) <<< (2 * FB)) - (WIDE'(prev2_re_reg) <<< FB);
            end
            OP_RIM: begin
                opnd = prev_im_reg;
                coef = tc_e;
                base = (WIDE'(x_im_reg) <<< (2 * FB)) - (WIDE'(prev2_im_reg) <<< FB);
            end
            OP_A: begin
                opnd = phase_reg[1] ? prev2_im_reg : prev2_re_reg;
                coef = phase_reg[1] ? sw_n : cw_n;
                base = WIDE'(prev_re_reg) <<< FB;
            end
            OP_B: begin
                opnd = phase_reg[1] ? prev2_re_reg : prev2_im_reg;
                coef = phase_reg[1] ? sw_e : cw_n;
                base = WIDE'(prev_im_reg) <<< FB;
            end
            OP_ORE: begin
                opnd = phase_reg[1] ? b_reg : a_reg;
                coef = phase_reg[1] ? rs_e : rc_e;
                base = '0;
            end
            OP_OIM: begin
                opnd = phase_reg[1] ? a_reg : b_reg;
                coef = phase_reg[1] ? rs_n : rc_e;
                base = '0;
            end
            default: begin
                opnd = '0;
                coef = '0;
                base = '0;
            end
        endcase
    end

    // half-width partial product: low half unsigned, high half signed
    assign mop = phase_reg[0] ? MW'($signed(opnd[ACC_WIDTH-1:H]))
                              : MW'($signed({1'b0, opnd[H-1:0]}));
    assign prod_next = mop * coef;
    assign addend    = half_reg ? (WIDE'(prod_reg) <<< H) : WIDE'(prod_reg);

    // round half up and drop the fraction
    assign rnd_sum  = acc_reg + (is_out_op ? (WIDE'(1) <<< (2 * FB - 1))
                                           : (WIDE'(1) <<< (FB - 1)));
    assign rnd_next = is_out_op ? (rnd_sum >>> (2 * FB)) : (rnd_sum >>> FB);

    // saturation to state width and to output width
    assign fits_acc = (&acc_reg[WIDE-1:ACC_WIDTH-1]) || !(|acc_reg[WIDE-1:ACC_WIDTH-1]);
    assign fits_out = (&acc_reg[WIDE-1:OW-1]) || !(|acc_reg[WIDE-1:OW-1]);
    assign sat_acc  = fits_acc ? acc_reg[ACC_WIDTH-1:0]
                    : (acc_reg[WIDE-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                       : {1'b0, {(ACC_WIDTH-1){1'b1}}});
    assign sat_out  = fits_out ? acc_reg[OW-1:0]
                    : (acc_reg[WIDE-1] ? {1'b1, {(OW-1){1'b0}}}
                                       : {1'b0, {(OW-1){1'b1}}});

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_im_reg, out_re_reg};

    // datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            x_re_reg <= q_data[SAMPLE_WIDTH-1:0];
            x_im_reg <= q_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
            last_reg <= q_data[2*SAMPLE_WIDTH];
        end
        unique case (state_reg)
            ST_MUL: begin
                acc_reg  <= (phase_reg == 2'd0) ? base : acc_reg + addend;
                prod_reg <= prod_next;
                half_reg <= phase_reg[0];
            end
            ST_DRAIN: acc_reg <= acc_reg + addend;
            ST_ROUND: acc_reg <= rnd_next;
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
        if (state_reg == ST_FIN) begin
            unique case (op_reg)
                OP_A:    a_reg   <= sat_acc;
                OP_B:    b_reg   <= sat_acc;
                OP_ORE:  ore_reg <= sat_out;
                OP_OIM: begin
                    if (!out_valid_reg) begin
                        out_re_reg <= ore_reg;
                        out_im_reg <= sat_out;
                    end
                end
                default: begin
                    a_reg <= a_reg;
                end
            endcase
        end
    end

    // sequencer, filter state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_RRE;
            phase_reg     <= '0;
            prev_re_reg   <= '0;
            prev_im_reg   <= '0;
            prev2_re_reg  <= '0;
            prev2_im_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        op_reg    <= OP_RRE;
                        phase_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (phase_reg == last_phase) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        phase_reg <= phase_reg + 1'b1;
                    end
                end
                ST_DRAIN: state_reg <= ST_ROUND;
                ST_ROUND: state_reg <= ST_FIN;
                ST_FIN: begin
                    phase_reg <= '0;
                    unique case (op_reg)
                        OP_RRE: begin
                            prev2_re_reg <= prev_re_reg;
                            prev_re_reg  <= sat_acc;
                            op_reg       <= OP_RIM;
                            state_reg    <= ST_MUL;
                        end
                        OP_RIM: begin
                            prev2_im_reg <= prev_im_reg;
                            prev_im_reg  <= sat_acc;
                            op_reg       <= OP_A;
                            state_reg    <= last_reg ? ST_MUL : ST_IDLE;
                        end
                        OP_A: begin
                            op_reg    <= OP_B;
                            state_reg <= ST_MUL;
                        end
                        OP_B: begin
                            op_reg    <= OP_ORE;
                            state_reg <= ST_MUL;
                        end
                        OP_ORE: begin
                            op_reg    <= OP_OIM;
                            state_reg <= ST_MUL;
                        end
                        OP_OIM: begin
                            // wait until the previous bin has left
                            if (!out_valid_reg) begin
                                out_valid_reg <= 1'b1;
                                prev_re_reg   <= '0;
                                prev_im_reg   <= '0;
                                prev2_re_reg  <= '0;
                                prev2_im_reg  <= '0;
                                state_reg     <= ST_IDLE;
                            end
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/gcb_checker.sv
// ----------------------------------------------------------------------------
// gcb_checker
// Port-level checks on the Goertzel bin block, bound to its top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled bin stays offered and unchanged
    `GCB_ASSERT(a_stall_valid, m_tvalid && !m_tready |=> m_tvalid, "bin dropped while stalled")
    `GCB_ASSERT(a_stall_data, m_tvalid && !m_tready |=> $stable(m_tdata), "bin changed while stalled")

    // bins are many cycles apart, so a taken word is never followed at once
    `GCB_ASSERT(a_bin_gap, m_tvalid && m_tready |=> !m_tvalid, "back-to-back bins")

    // reset empties the output register and the queue
    `GCB_ASSERT_RST(a_reset_out, !aresetn |=> !m_tvalid, "bin valid after reset")
    `GCB_ASSERT_RST(a_reset_in, !aresetn |=> s_tready, "intake not ready after reset")

endmodule

bind goertzel_complex_bin_top gcb_checker u_gcb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
